// ===== rtl/core/two_wheel_odometry_update_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-wheel odometry core
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_WHEEL_ODOMETRY_UPDATE_CORE_MACROS_SVH
`define TWO_WHEEL_ODOMETRY_UPDATE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TWOD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometry core check failed");

// The consequent must hold in the cycle after the antecedent.
`define TWOD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry core check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define TWOD_ASSERT_LATER(label, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("odometry core check failed");

`endif

// ===== rtl/core/twod_pkg.sv =====
// ----------------------------------------------------------------------------
// twod_pkg
// Types, constants and the arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package twod_pkg;

	// Beat carried on the update channel.
	typedef struct packed {
		logic               mode;
		logic signed [31:0] forward_reading;
		logic signed [31:0] sideways_reading;
		logic signed [31:0] heading_in;
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
	} upd_item_t;

	// Beat carried on the pose channel.
	typedef struct packed {
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
	} pose_item_t;

	// Input mode codes.
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_SET    = 1'b1;

	// Register indexes (selected by paddr[2]).
	localparam logic REG_FWD_OFFSET  = 1'b0;
	localparam logic REG_SIDE_OFFSET = 1'b1;

	localparam logic signed [31:0] FWD_OFFSET_RST  = -32'sd5083;
	localparam logic signed [31:0] SIDE_OFFSET_RST = 32'sd45720;

	// Iteration counts.
	localparam int CORDIC_STEPS = 24;
	localparam int DIV_STEPS    = 64;
	localparam int CNT_W        = 7;

	// Datapath widths.
	localparam int XY_W    = 56;
	localparam int Z_W     = 34;
	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 34;
	localparam int PROD_W  = 74;
	localparam int LXY_W   = 36;
	localparam int DVD_W   = 64;
	localparam int DSR_W   = 40;
	localparam int REM_W   = 41;

	// Fixed-point scale factors.
	localparam logic signed [31:0] CORDIC_K_Q30    = 32'sd652032874;
	localparam logic signed [24:0] CORDIC_KK_Q24   = 25'sd6186701;
	localparam logic signed [24:0] DEG_TO_ANG      = 25'sd11930465;
	localparam logic signed [24:0] DEG_TO_HALF_RAD = 25'sd9370166;

	// Arctangent of 2^-i in binary angle units (2^32 per turn).
	function automatic logic [31:0] atan_ang(input logic [4:0] idx);
		logic [31:0] a;
		case (idx)
			5'd0:  a = 32'd536870912;
			5'd1:  a = 32'd316933406;
			5'd2:  a = 32'd167458907;
			5'd3:  a = 32'd85004756;
			5'd4:  a = 32'd42667331;
			5'd5:  a = 32'd21354465;
			5'd6:  a = 32'd10679838;
			5'd7:  a = 32'd5340245;
			5'd8:  a = 32'd2670163;
			5'd9:  a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/core/two_wheel_odometry_update_core.sv =====
// ----------------------------------------------------------------------------
// two_wheel_odometry_update_core
// Dead-reckoning pose tracker for two tracking wheels and a heading input,
// built around one shared multiplier, one shared CORDIC stage and a
// bit-serial divider under a small sequencer.
//
// Channel  | Direction | Handshake               | Beat
// upd      | in        | upd_valid / upd_ready   | upd_item_t
// pose     | out       | pose_valid / pose_ready | pose_item_t
// apb      | in/out    | psel, penable, pready   | 32-bit register
//
// A set beat goes straight to the output state. An update with no turn runs
// two CORDIC passes of 24 steps; one with a turn adds a third pass and a
// 64-step restoring divider. With no move the vectoring and final rotation
// passes are skipped.
// upd_ready is high only while the sequencer is idle.
// A result waiting on pose_ready holds the sequencer in its output state.
// Reset clears the pose and the wheel baselines and loads the default offsets.
// ----------------------------------------------------------------------------
module two_wheel_odometry_update_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd_valid,
	output logic                   upd_ready,
	input  twod_pkg::upd_item_t    upd,
	output logic                   pose_valid,
	input  logic                   pose_ready,
	output twod_pkg::pose_item_t   pose,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import twod_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_HEAD, S_HALF, S_HRAD, S_HCAP, S_ROT1, S_SCAP, S_DIV,
		S_FSAT, S_FSD, S_LX1, S_LX2, S_LY1, S_LY2, S_VCHK, S_VEC,
		S_LEN, S_GX, S_ROT2, S_ACC, S_PUT
	} state_t;

	localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      pose_valid_q;
	pose_item_t                pose_q;
	logic signed [31:0]        pose_x_q, pose_y_q;
	logic signed [31:0]        last_fwd_q, last_side_q, last_head_q;
	logic signed [31:0]        fwd_off_q, side_off_q;

	// Datapath registers.
	logic signed [31:0]        fd_q, sd_q, dh_q, prevh_q;
	logic [31:0]               prev_ang_q, half_ang_q, base_q, rot_ang_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [XY_W-1:0]    cx_q, cy_q;
	logic signed [Z_W-1:0]     cz_q;
	logic signed [Z_W-1:0]     s_q;
	logic [DSR_W-1:0]          dsr_q;
	logic                      h_neg_q;
	logic [DVD_W-1:0]          dvd_q;
	logic [REM_W-1:0]          rem_q;
	logic signed [32:0]        f_q;
	logic signed [LXY_W-1:0]   t_q, lx_q, ly_q;

	logic                      upd_acc;
	logic                      cfg_wr;
	logic                      put_go;
	logic                      last_step;

	// Handshake and configuration port.
	assign upd_acc    = upd_valid && upd_ready;
	assign upd_ready  = (state_q == S_IDLE);
	assign pose_valid = pose_valid_q;
	assign pose       = pose_q;
	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign prdata     = (paddr[2] == REG_SIDE_OFFSET) ? side_off_q : fwd_off_q;
	assign put_go     = (state_q == S_PUT) && (!pose_valid_q || pose_ready);

	// The shared counter ends a CORDIC pass or the divider.
	assign last_step = (state_q == S_DIV) ? (cnt_q == DIV_LAST) : (cnt_q == CORDIC_LAST);

	// Operand selection for the shared multiplier.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_HEAD: begin
				mul_a = MUL_A_W'(prevh_q);
				mul_b = MUL_B_W'(DEG_TO_ANG);
			end
			S_HALF: begin
				mul_a = MUL_A_W'(dh_q);
				mul_b = MUL_B_W'(DEG_TO_ANG);
			end
			S_HRAD: begin
				mul_a = MUL_A_W'(dh_q);
				mul_b = MUL_B_W'(DEG_TO_HALF_RAD);
			end
			S_FSD: begin
				mul_a = MUL_A_W'(f_q);
				mul_b = MUL_B_W'(sd_q);
			end
			S_LX1: begin
				mul_a = MUL_A_W'(s_q);
				mul_b = MUL_B_W'(side_off_q);
			end
			S_LX2: begin
				mul_a = MUL_A_W'(f_q);
				mul_b = MUL_B_W'(fd_q);
			end
			S_LY1: begin
				mul_a = MUL_A_W'(s_q);
				mul_b = MUL_B_W'(fwd_off_q);
			end
			S_LEN: begin
				mul_a = cx_q[XY_W-1:16];
				mul_b = MUL_B_W'(CORDIC_KK_Q24);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// One CORDIC micro-rotation, shared by rotation and vectoring passes.
	logic [4:0]              sh;
	logic signed [XY_W-1:0]  dx, dy, nx, ny;
	logic signed [Z_W-1:0]   step_ang, nz;
	logic                    ypos, turn_neg;

	always_comb begin
		sh       = cnt_q[4:0];
		dx       = cy_q >>> sh;
		dy       = cx_q >>> sh;
		step_ang = Z_W'(atan_ang(cnt_q[4:0]));
		ypos     = !cy_q[XY_W-1] && (cy_q != '0);
		turn_neg = (state_q == S_VEC) ? !ypos : !cz_q[Z_W-1];
		if (turn_neg) begin
			nx = cx_q - dx;
			ny = cy_q + dy;
			nz = cz_q - step_ang;
		end else begin
			nx = cx_q + dx;
			ny = cy_q - dy;
			nz = cz_q + step_ang;
		end
	end

	// Start of a rotation pass: fold the angle into the right half-plane.
	logic signed [XY_W-1:0]  rot_x;
	logic [31:0]             rot_ang, rot_sum, rot_fold_ang;
	logic                    rot_fold;

	always_comb begin
		if (state_q == S_GX) begin
			rot_x   = prod_q[XY_W+7:8];
			rot_ang = rot_ang_q;
		end else begin
			rot_x   = XY_W'(CORDIC_K_Q30);
			rot_ang = half_ang_q;
		end
		rot_sum      = rot_ang + 32'h4000_0000;
		rot_fold     = rot_sum[31];
		rot_fold_ang = rot_fold ? (rot_ang + 32'h8000_0000) : rot_ang;
	end

	// One restoring division step, and the saturated chord factor.
	logic [REM_W:0]   div_shift, div_diff;
	logic             div_ge;
	logic [REM_W-1:0] rem_next;
	logic [31:0]      f_mag;
	logic signed [32:0] f_sat;

	always_comb begin
		div_shift = {rem_q, dvd_q[DVD_W-1]};
		div_diff  = div_shift - {2'b00, dsr_q};
		div_ge    = !div_diff[REM_W];
		rem_next  = div_ge ? div_diff[REM_W-1:0] : div_shift[REM_W-1:0];
		f_mag     = (|dvd_q[DVD_W-1:31]) ? 32'h8000_0000 : {1'b0, dvd_q[30:0]};
		f_sat     = (s_q[Z_W-1] ^ h_neg_q) ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
	end

	// Half-turn in radians, forced nonzero.
	logic signed [DSR_W-1:0] h_val;
	logic [Z_W-1:0]          s_mag;

	always_comb begin
		h_val = prod_q[DSR_W+15:16];
		if (h_val == '0) begin
			h_val = DSR_W'(1);
		end
		s_mag = s_q[Z_W-1] ? Z_W'(-s_q) : Z_W'(s_q);
	end

	// Local move scaled to Q16, sign-extended to the CORDIC width.
	logic signed [XY_W-1:0]  lx_ext, ly_ext;

	assign lx_ext = XY_W'($signed({lx_q, 16'b0}));
	assign ly_ext = XY_W'($signed({ly_q, 16'b0}));

	// Datapath registers, loaded under the sequencer.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (upd_acc) begin
			fd_q    <= upd.forward_reading - last_fwd_q;
			sd_q    <= upd.sideways_reading - last_side_q;
			dh_q    <= upd.heading_in - last_head_q;
			prevh_q <= last_head_q;
		end
		case (state_q)
			S_HALF: prev_ang_q <= prod_q[47:16];
			S_HRAD: half_ang_q <= prod_q[48:17];
			S_HCAP: begin
				dsr_q   <= h_val[DSR_W-1] ? DSR_W'(-h_val) : DSR_W'(h_val);
				h_neg_q <= h_val[DSR_W-1];
				lx_q    <= LXY_W'(sd_q);
				ly_q    <= LXY_W'(fd_q);
				cx_q    <= rot_fold ? -rot_x : rot_x;
				cy_q    <= '0;
				cz_q    <= Z_W'($signed(rot_fold_ang));
			end
			S_ROT1, S_VEC, S_ROT2: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
				if (state_q == S_ROT1) begin
					s_q <= ny[Z_W-1:0];
				end
			end
			S_SCAP: begin
				dvd_q <= {s_mag[Z_W-1:0], 30'b0};
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[DVD_W-2:0], div_ge};
			end
			S_FSAT: f_q <= f_sat;
			S_LX1, S_LY1: t_q <= prod_q[LXY_W+29:30];
			S_LX2: lx_q <= t_q + prod_q[LXY_W+28:29];
			S_LY2: ly_q <= t_q + prod_q[LXY_W+28:29];
			S_VCHK: begin
				cx_q   <= lx_q[LXY_W-1] ? -lx_ext : lx_ext;
				cy_q   <= lx_q[LXY_W-1] ? -ly_ext : ly_ext;
				cz_q   <= '0;
				base_q <= lx_q[LXY_W-1] ? 32'h8000_0000 : 32'h0;
			end
			S_LEN: rot_ang_q <= base_q + cz_q[31:0] - prev_ang_q - half_ang_q;
			S_GX: begin
				cx_q <= rot_fold ? -rot_x : rot_x;
				cy_q <= '0;
				cz_q <= Z_W'($signed(rot_fold_ang));
			end
			default: begin
			end
		endcase
	end

	// Sequencer, pose state, baselines, offsets and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			pose_valid_q <= 1'b0;
			pose_q       <= '0;
			pose_x_q     <= '0;
			pose_y_q     <= '0;
			last_fwd_q   <= '0;
			last_side_q  <= '0;
			last_head_q  <= '0;
			fwd_off_q    <= FWD_OFFSET_RST;
			side_off_q   <= SIDE_OFFSET_RST;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_FWD_OFFSET) begin
					fwd_off_q <= pwdata;
				end else begin
					side_off_q <= pwdata;
				end
			end
			if (pose_valid_q && pose_ready && !put_go) begin
				pose_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (upd_acc) begin
						last_fwd_q  <= upd.forward_reading;
						last_side_q <= upd.sideways_reading;
						last_head_q <= upd.heading_in;
						if (upd.mode == MODE_SET) begin
							pose_x_q <= upd.new_x;
							pose_y_q <= upd.new_y;
							state_q  <= S_PUT;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: state_q <= S_HALF;
				S_HALF: state_q <= S_HRAD;
				S_HRAD: state_q <= S_HCAP;
				S_HCAP: begin
					cnt_q   <= '0;
					state_q <= (dh_q == '0) ? S_VCHK : S_ROT1;
				end
				S_ROT1: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= S_SCAP;
					end
				end
				S_SCAP: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= S_FSAT;
					end
				end
				S_FSAT: state_q <= S_FSD;
				S_FSD:  state_q <= S_LX1;
				S_LX1:  state_q <= S_LX2;
				S_LX2:  state_q <= S_LY1;
				S_LY1:  state_q <= S_LY2;
				S_LY2:  state_q <= S_VCHK;
				S_VCHK: begin
					cnt_q   <= '0;
					state_q <= (lx_q == '0 && ly_q == '0) ? S_PUT : S_VEC;
				end
				S_VEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: state_q <= S_GX;
				S_GX: begin
					cnt_q   <= '0;
					state_q <= S_ROT2;
				end
				S_ROT2: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					pose_x_q <= pose_x_q + cx_q[47:16];
					pose_y_q <= pose_y_q + cy_q[47:16];
					state_q  <= S_PUT;
				end
				S_PUT: begin
					if (put_go) begin
						pose_q.x_out <= pose_x_q;
						pose_q.y_out <= pose_y_q;
						pose_valid_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/twod_core_checker.sv =====
// ----------------------------------------------------------------------------
// twod_core_checker
// Port-level checks of the odometry core, bound to its top level.
// ----------------------------------------------------------------------------
`include "two_wheel_odometry_update_core_macros.svh"

module twod_core_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd_valid,
	input  logic                   upd_ready,
	input  twod_pkg::upd_item_t    upd,
	input  logic                   pose_valid,
	input  logic                   pose_ready,
	input  twod_pkg::pose_item_t   pose,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic [31:0]            prdata,
	input  logic                   pready
);
	import twod_pkg::*;

	// The register port never inserts wait states.
	`TWOD_ASSERT_NOW(a_pready_high, psel, pready)

	// An accepted beat keeps the core busy in the following cycle.
	`TWOD_ASSERT_NEXT(a_busy_after_beat, upd_valid && upd_ready, !upd_ready)

	// A stalled result beat holds its value.
	`TWOD_ASSERT_NEXT(a_pose_hold, pose_valid && !pose_ready, pose_valid && $stable(pose))

	// A set beat on a free output passes through the output state before its result is shown.
	`TWOD_ASSERT_LATER(a_set_latency, upd_valid && upd_ready && (upd.mode == MODE_SET) && !pose_valid, 2, pose_valid)

endmodule

bind two_wheel_odometry_update_core twod_core_checker u_twod_core_checker (.*);
